/* src/sed_pkg.sv */
package sed_pkg;

  // escape decoder phase, one-hot
  typedef enum logic [3:0] {
    PH_PLAIN = 4'b0001,
    PH_ESC   = 4'b0010,
    PH_HEX   = 4'b0100,
    PH_OCT   = 4'b1000
  } phase_t;

  // character codes
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_V      = 8'h76;

  // control bytes the letter escapes map to
  localparam logic [7:0] CTL_BEL = 8'h07;
  localparam logic [7:0] CTL_BS  = 8'h08;
  localparam logic [7:0] CTL_ESC = 8'h1b;
  localparam logic [7:0] CTL_FF  = 8'h0c;
  localparam logic [7:0] CTL_LF  = 8'h0a;
  localparam logic [7:0] CTL_CR  = 8'h0d;
  localparam logic [7:0] CTL_TAB = 8'h09;
  localparam logic [7:0] CTL_VT  = 8'h0b;

  // most decoded bytes one input word can produce
  localparam int unsigned MAX_RES = 3;

  typedef struct packed {
    phase_t     phase;
    logic [1:0] digit_count;
    logic [7:0] value_acc;
  } sed_state_t;

  typedef struct packed {
    sed_state_t       state;
    logic [1:0]       count;
    logic [2:0][7:0]  bytes;
  } sed_dec_t;

endpackage

/* src/sed_ifs.sv */
// raw string byte channel
interface sed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_final;

  modport source (output valid, output in_byte, output in_final, input ready);
  modport sink   (input valid, input in_byte, input in_final, output ready);
endinterface

// decoded byte channel
interface sed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       string_end;

  modport source (output valid, output out_byte, output run_end, output string_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_end, input string_end,
                  output ready);
endinterface

/* src/sed_decode.sv */
module sed_decode (
  input  sed_pkg::sed_state_t state,
  input  logic [7:0]          in_byte,
  input  logic                in_final,
  output sed_pkg::sed_dec_t   dec
);

  logic [7:0] b;
  logic       fin;
  logic       hex_ok;
  logic [3:0] hex_d;
  logic       oct_ok;
  logic [7:0] hex_v;
  logic [7:0] oct_v;
  logic [1:0] oct_cnt;
  logic       do_plain;

  assign b   = in_byte;
  assign fin = in_final;

  // digit classification
  always_comb begin
    hex_ok = 1'b0;
    hex_d  = b[3:0];
    if (b inside {["0":"9"]}) begin
      hex_ok = 1'b1;
    end else if (b inside {["a":"f"], ["A":"F"]}) begin
      hex_ok = 1'b1;
      hex_d  = b[3:0] + 4'd9;
    end
  end

  assign oct_ok  = b inside {["0":"7"]};
  assign hex_v   = {state.value_acc[3:0], hex_d};
  assign oct_v   = {state.value_acc[4:0], b[2:0]};
  assign oct_cnt = state.digit_count + 2'd1;

  // one pass of the escape decoder
  always_comb begin
    dec.state.phase       = sed_pkg::PH_PLAIN;
    dec.state.digit_count = state.digit_count;
    dec.state.value_acc   = state.value_acc;
    dec.count             = 2'd0;
    dec.bytes             = '0;
    do_plain              = 1'b0;

    case (state.phase)
      sed_pkg::PH_ESC: begin
        case (b)
          sed_pkg::CH_A: begin dec.bytes[0] = sed_pkg::CTL_BEL; dec.count = 2'd1; end
          sed_pkg::CH_B: begin dec.bytes[0] = sed_pkg::CTL_BS;  dec.count = 2'd1; end
          sed_pkg::CH_E: begin dec.bytes[0] = sed_pkg::CTL_ESC; dec.count = 2'd1; end
          sed_pkg::CH_F: begin dec.bytes[0] = sed_pkg::CTL_FF;  dec.count = 2'd1; end
          sed_pkg::CH_N: begin dec.bytes[0] = sed_pkg::CTL_LF;  dec.count = 2'd1; end
          sed_pkg::CH_R: begin dec.bytes[0] = sed_pkg::CTL_CR;  dec.count = 2'd1; end
          sed_pkg::CH_T: begin dec.bytes[0] = sed_pkg::CTL_TAB; dec.count = 2'd1; end
          sed_pkg::CH_V: begin dec.bytes[0] = sed_pkg::CTL_VT;  dec.count = 2'd1; end
          sed_pkg::CH_BSLASH, sed_pkg::CH_SQUOTE, sed_pkg::CH_DQUOTE: begin
            dec.bytes[0] = b;
            dec.count    = 2'd1;
          end
          sed_pkg::CH_X, sed_pkg::CH_ZERO: begin
            if (fin) begin
              dec.bytes[0] = sed_pkg::CH_BSLASH;
              dec.bytes[1] = b;
              dec.count    = 2'd2;
            end else begin
              dec.state.phase = (b == sed_pkg::CH_X) ? sed_pkg::PH_HEX : sed_pkg::PH_OCT;
              dec.state.digit_count = 2'd0;
              dec.state.value_acc   = 8'd0;
            end
          end
          default: begin
            dec.bytes[0] = sed_pkg::CH_BSLASH;
            dec.bytes[1] = b;
            dec.count    = 2'd2;
          end
        endcase
      end
      sed_pkg::PH_HEX: begin
        if (hex_ok) begin
          if (state.digit_count == 2'd0 && !fin) begin
            dec.state.value_acc   = hex_v;
            dec.state.digit_count = 2'd1;
            dec.state.phase       = sed_pkg::PH_HEX;
          end else begin
            dec.bytes[0] = hex_v;
            dec.count    = 2'd1;
          end
        end else begin
          if (state.digit_count == 2'd0) begin
            dec.bytes[0] = sed_pkg::CH_BSLASH;
            dec.bytes[1] = sed_pkg::CH_X;
            dec.count    = 2'd2;
          end else begin
            dec.bytes[0] = state.value_acc;
            dec.count    = 2'd1;
          end
          do_plain = 1'b1;
        end
      end
      sed_pkg::PH_OCT: begin
        if (oct_ok) begin
          dec.state.value_acc   = oct_v;
          dec.state.digit_count = oct_cnt;
          if (oct_cnt == 2'd3 || fin) begin
            dec.bytes[0] = oct_v;
            dec.count    = 2'd1;
          end else begin
            dec.state.phase = sed_pkg::PH_OCT;
          end
        end else begin
          if (state.digit_count == 2'd0) begin
            dec.bytes[0] = sed_pkg::CH_BSLASH;
            dec.bytes[1] = sed_pkg::CH_ZERO;
            dec.count    = 2'd2;
          end else begin
            dec.bytes[0] = state.value_acc;
            dec.count    = 2'd1;
          end
          do_plain = 1'b1;
        end
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase

    // plain text handling of the current byte, after any flushed escape
    if (do_plain) begin
      if (b == sed_pkg::CH_BSLASH && !fin) begin
        dec.state.phase = sed_pkg::PH_ESC;
      end else begin
        dec.bytes[dec.count] = b;
        dec.count            = dec.count + 2'd1;
      end
    end

    // leave numeric state clean outside an escape and at end of string
    if (dec.state.phase == sed_pkg::PH_PLAIN || fin) begin
      dec.state.phase       = sed_pkg::PH_PLAIN;
      dec.state.digit_count = 2'd0;
      dec.state.value_acc   = 8'd0;
    end
  end

endmodule

/* src/string_escape_decoder.sv */
// channel  modport  payload                             role
// in_s     sink     in_byte[7:0], in_final              raw string body bytes
// out_s    source   out_byte[7:0], run_end, string_end  decoded bytes
//
// each input word is decoded combinationally into 0 to 3 bytes held in a result buffer
// the buffer drains one byte per cycle while out_s is ready
// a new word is taken in the cycle the last buffered byte leaves, or when it is empty
// rst_n is synchronous, active low; it clears the escape state and empties the buffer
// a stalled out_s holds its byte and holds off in_s once the buffer is not draining
module string_escape_decoder (
  input logic      clk,
  input logic      rst_n,
  sed_in_if.sink   in_s,
  sed_out_if.source out_s
);

  sed_pkg::sed_state_t st_r;
  sed_pkg::sed_dec_t   dec;
  logic [2:0][7:0]     buf_r;
  logic [1:0]          n_r;
  logic [1:0]          rd_r;
  logic                fin_r;
  logic                in_acc;
  logic                out_acc;

  // combinational decode of the offered word
  sed_decode u_decode (
    .state    (st_r),
    .in_byte  (in_s.in_byte),
    .in_final (in_s.in_final),
    .dec      (dec)
  );

  // handshakes
  assign out_acc    = out_s.valid && out_s.ready;
  assign in_s.ready = (n_r == 2'd0) || (n_r == 2'd1 && out_s.ready);
  assign in_acc     = in_s.valid && in_s.ready;

  // escape state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase       <= sed_pkg::PH_PLAIN;
      st_r.digit_count <= 2'd0;
      st_r.value_acc   <= 8'd0;
    end else if (in_acc) begin
      st_r <= dec.state;
    end
  end

  // result buffer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r  <= 2'd0;
      rd_r <= 2'd0;
    end else if (in_acc) begin
      n_r  <= dec.count;
      rd_r <= 2'd0;
    end else if (out_acc) begin
      n_r  <= n_r - 2'd1;
      rd_r <= rd_r + 2'd1;
    end
  end

  // result buffer payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      buf_r <= dec.bytes;
      fin_r <= in_s.in_final;
    end
  end

  // output word
  assign out_s.valid      = (n_r != 2'd0);
  assign out_s.out_byte   = buf_r[rd_r];
  assign out_s.run_end    = (n_r == 2'd1);
  assign out_s.string_end = (n_r == 2'd1) && fin_r;

  // checks
  a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_s.valid |-> ({1'b0, rd_r} + {1'b0, n_r}) <= 3'(sed_pkg::MAX_RES))
    else $error("result buffer read past its fill");

  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && dec.count == 2'd0) |=> !out_s.valid)
    else $error("word with no result left a byte pending");

  a_run_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_s.run_end && !in_acc) |=> !out_s.valid)
    else $error("byte pending after the last byte of a run");

  a_str_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_s.string_end) |-> (st_r.phase == sed_pkg::PH_PLAIN &&
                                       st_r.digit_count == 2'd0))
    else $error("escape state not cleared at end of string");

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 60;
  localparam int IDLE_PCT       = 31;
  localparam int SETTLE_CYCLES  = 10;

  // character codes not in the package
  localparam logic [7:0] CH_SEVEN   = 8'h37;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       string_end;
  } dec_byte_t;

  logic clk;
  logic rst_n;

  sed_in_if  in_if ();
  sed_out_if out_if ();

  string_escape_decoder uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_if),
    .out_s (out_if)
  );

  // decoder state mirror
  sed_pkg::phase_t dec_phase;
  logic [1:0]      dec_count;
  logic [7:0]      dec_acc;

  logic [7:0] word_bytes[$];
  dec_byte_t  expected_bytes[$];
  logic [7:0] text_bytes[$];

  logic [7:0] letter_codes[8] = '{sed_pkg::CH_A, sed_pkg::CH_B, sed_pkg::CH_E, sed_pkg::CH_F,
                                  sed_pkg::CH_N, sed_pkg::CH_R, sed_pkg::CH_T, sed_pkg::CH_V};
  logic [7:0] quote_codes[3]  = '{sed_pkg::CH_BSLASH, sed_pkg::CH_SQUOTE, sed_pkg::CH_DQUOTE};

  int  words_sent;
  int  bytes_checked;
  int  mismatches;
  int  stuck_cycles;
  int  hold_request;
  int  hold_left;
  bit  src_idle_on;
  bit  sink_idle_on;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void emit_byte(input logic [7:0] b);
    word_bytes.push_back(b);
  endfunction

  function automatic void decode_plain(input logic [7:0] b, input logic fin);
    if (b == sed_pkg::CH_BSLASH && !fin) begin
      dec_phase = sed_pkg::PH_ESC;
    end else begin
      emit_byte(b);
    end
  endfunction

  function automatic int nibble_of(input logic [7:0] b);
    if (b >= sed_pkg::CH_ZERO && b <= CH_NINE) return int'(b) - int'(sed_pkg::CH_ZERO);
    if (b >= sed_pkg::CH_A && b <= sed_pkg::CH_F) return int'(b) - int'(sed_pkg::CH_A) + 10;
    if (b >= CH_UPPER_A && b <= CH_UPPER_F) return int'(b) - int'(CH_UPPER_A) + 10;
    return -1;
  endfunction

  // work out the decoded bytes one raw word yields and queue them
  function automatic void predict_word(input logic [7:0] b, input logic fin);
    sed_pkg::phase_t prior;
    int              digit;
    logic [7:0]      merged;
    dec_byte_t       item;
    prior = dec_phase;
    word_bytes.delete();
    dec_phase = sed_pkg::PH_PLAIN;
    case (prior)
      sed_pkg::PH_ESC: begin
        case (b)
          sed_pkg::CH_A: emit_byte(sed_pkg::CTL_BEL);
          sed_pkg::CH_B: emit_byte(sed_pkg::CTL_BS);
          sed_pkg::CH_E: emit_byte(sed_pkg::CTL_ESC);
          sed_pkg::CH_F: emit_byte(sed_pkg::CTL_FF);
          sed_pkg::CH_N: emit_byte(sed_pkg::CTL_LF);
          sed_pkg::CH_R: emit_byte(sed_pkg::CTL_CR);
          sed_pkg::CH_T: emit_byte(sed_pkg::CTL_TAB);
          sed_pkg::CH_V: emit_byte(sed_pkg::CTL_VT);
          sed_pkg::CH_BSLASH, sed_pkg::CH_SQUOTE, sed_pkg::CH_DQUOTE: emit_byte(b);
          sed_pkg::CH_X, sed_pkg::CH_ZERO: begin
            if (fin) begin
              emit_byte(sed_pkg::CH_BSLASH);
              emit_byte(b);
            end else begin
              dec_phase = (b == sed_pkg::CH_X) ? sed_pkg::PH_HEX : sed_pkg::PH_OCT;
              dec_count = 2'd0;
              dec_acc   = 8'd0;
            end
          end
          default: begin
            emit_byte(sed_pkg::CH_BSLASH);
            emit_byte(b);
          end
        endcase
      end
      sed_pkg::PH_HEX: begin
        digit = nibble_of(b);
        if (digit >= 0) begin
          merged = {dec_acc[3:0], 4'(digit)};
          if (dec_count == 2'd0 && !fin) begin
            dec_acc   = merged;
            dec_count = 2'd1;
            dec_phase = sed_pkg::PH_HEX;
          end else begin
            emit_byte(merged);
          end
        end else begin
          // digitless x is kept literally, the ending byte decodes as usual
          if (dec_count == 2'd0) begin
            emit_byte(sed_pkg::CH_BSLASH);
            emit_byte(sed_pkg::CH_X);
          end else begin
            emit_byte(dec_acc);
          end
          decode_plain(b, fin);
        end
      end
      sed_pkg::PH_OCT: begin
        if (b >= sed_pkg::CH_ZERO && b <= CH_SEVEN) begin
          dec_acc   = {dec_acc[4:0], b[2:0]};
          dec_count = dec_count + 2'd1;
          if (dec_count == 2'd3 || fin) begin
            emit_byte(dec_acc);
          end else begin
            dec_phase = sed_pkg::PH_OCT;
          end
        end else begin
          if (dec_count == 2'd0) begin
            emit_byte(sed_pkg::CH_BSLASH);
            emit_byte(sed_pkg::CH_ZERO);
          end else begin
            emit_byte(dec_acc);
          end
          decode_plain(b, fin);
        end
      end
      default: decode_plain(b, fin);
    endcase
    if (dec_phase == sed_pkg::PH_PLAIN || fin) begin
      dec_phase = sed_pkg::PH_PLAIN;
      dec_count = 2'd0;
      dec_acc   = 8'd0;
    end
    foreach (word_bytes[i]) begin
      item.data       = word_bytes[i];
      item.run_end    = (i == word_bytes.size() - 1);
      item.string_end = fin && (i == word_bytes.size() - 1);
      expected_bytes.push_back(item);
    end
  endfunction

  // compare one decoded byte with the oldest expected one
  function automatic void check_word(input dec_byte_t got);
    dec_byte_t want;
    if (expected_bytes.size() == 0) begin
      $display("%0t: unexpected decoded byte, actual %h run_end %b string_end %b",
               $time, got.data, got.run_end, got.string_end);
      mismatches++;
      return;
    end
    want = expected_bytes.pop_front();
    bytes_checked++;
    if (got.data !== want.data) begin
      $display("%0t: out_byte expected %h actual %h", $time, want.data, got.data);
      mismatches++;
    end
    if (got.run_end !== want.run_end) begin
      $display("%0t: run_end expected %b actual %b", $time, want.run_end, got.run_end);
      mismatches++;
    end
    if (got.string_end !== want.string_end) begin
      $display("%0t: string_end expected %b actual %b", $time, want.string_end,
               got.string_end);
      mismatches++;
    end
  endfunction

  // predict on accepted input words, check accepted output words
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        predict_word(in_if.in_byte, in_if.in_final);
      end
      if (out_if.valid && out_if.ready) begin
        check_word('{out_if.out_byte, out_if.run_end, out_if.string_end});
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d bytes still expected",
               $time, stuck_cycles, expected_bytes.size());
      $display("[string_escape_decoder] ERROR");
      $finish;
    end
  end

  // output ready: random stalls plus requested long hold
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_if.ready = 1'b0;
      hold_left--;
    end else begin
      out_if.ready = !(sink_idle_on && $urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // offer one raw word and wait until it is taken
  task automatic send_word(input logic [7:0] b, input logic fin);
    @(negedge clk);
    while (src_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid    = 1'b1;
    in_if.in_byte  = b;
    in_if.in_final = fin;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    words_sent++;
  endtask

  task automatic send_text(input string s, input bit fin_last);
    for (int i = 0; i < s.len(); i++) begin
      send_word(s[i], fin_last && (i == s.len() - 1));
    end
  endtask

  // stop offering and wait for every expected byte
  task automatic wait_drained();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] hex_char(input int unsigned v);
    if (v < 10) return 8'(sed_pkg::CH_ZERO + v);
    return 8'(($urandom_range(0, 1) ? CH_UPPER_A : sed_pkg::CH_A) + v - 10);
  endfunction

  // append one piece of string body, mostly well formed
  task automatic add_piece();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      text_bytes.push_back(8'($urandom_range(8'h20, 8'h7e)));
    end else if (pick < 48) begin
      text_bytes.push_back(sed_pkg::CH_BSLASH);
      text_bytes.push_back(letter_codes[$urandom_range(0, 7)]);
    end else if (pick < 56) begin
      text_bytes.push_back(sed_pkg::CH_BSLASH);
      text_bytes.push_back(quote_codes[$urandom_range(0, 2)]);
    end else if (pick < 70) begin
      text_bytes.push_back(sed_pkg::CH_BSLASH);
      text_bytes.push_back(sed_pkg::CH_X);
      repeat ($urandom_range(1, 2)) text_bytes.push_back(hex_char($urandom_range(0, 15)));
    end else if (pick < 84) begin
      text_bytes.push_back(sed_pkg::CH_BSLASH);
      text_bytes.push_back(sed_pkg::CH_ZERO);
      repeat ($urandom_range(1, 3))
        text_bytes.push_back(8'(sed_pkg::CH_ZERO + $urandom_range(0, 7)));
    end else if (pick < 92) begin
      text_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      // broken escape: x or 0 or nothing after the backslash, then a random byte
      text_bytes.push_back(sed_pkg::CH_BSLASH);
      case ($urandom_range(0, 2))
        0: text_bytes.push_back(sed_pkg::CH_X);
        1: text_bytes.push_back(sed_pkg::CH_ZERO);
        default: ;
      endcase
      text_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // one random string, sometimes with its last byte dropped
  task automatic send_random_string();
    text_bytes.delete();
    repeat ($urandom_range(1, 6)) add_piece();
    if (text_bytes.size() > 1 && $urandom_range(0, 9) == 0) begin
      void'(text_bytes.pop_back());
    end
    foreach (text_bytes[i]) begin
      send_word(text_bytes[i], i == text_bytes.size() - 1);
    end
  endtask

  task automatic test_plain_bytes();
    send_word(8'h00, 1'b0);
    send_word(8'hff, 1'b0);
  endtask

  task automatic test_letter_escape();
    send_text("\\n", 1'b0);
  endtask

  task automatic test_hex_escapes();
    send_text("\\x4F", 1'b0);
    // digitless x followed by a new escape
    send_text("\\x\\t", 1'b0);
  endtask

  task automatic test_octal_escapes();
    // three digits overflow past 8 bits
    send_text("\\0777", 1'b0);
    // value ended by a non-digit
    send_text("\\01g", 1'b0);
  endtask

  task automatic test_string_ends();
    // hex escape cut by the final word
    send_text("\\xA", 1'b1);
    // lone backslash as the final word
    send_text("\\", 1'b1);
  endtask

  task automatic test_receiver_hold();
    hold_request = HOLD_CYCLES;
    repeat (4) send_text("\\q\\x7g", 1'b0);
    send_text("\\0", 1'b1);
    wait_drained();
  endtask

  task automatic test_sender_pause();
    send_text("\\t\\x41", 1'b1);
    wait_drained();
    send_text("ok", 1'b1);
  endtask

  task automatic test_random_strings(input int target);
    while (words_sent < target) send_random_string();
  endtask

  initial begin
    in_if.valid     = 1'b0;
    in_if.in_byte   = 8'd0;
    in_if.in_final  = 1'b0;
    out_if.ready    = 1'b0;
    rst_n           = 1'b0;
    src_idle_on     = 1'b1;
    sink_idle_on    = 1'b1;
    hold_request    = 0;
    hold_left       = 0;
    words_sent      = 0;
    bytes_checked   = 0;
    mismatches      = 0;
    stuck_cycles    = 0;
    dec_phase       = sed_pkg::PH_PLAIN;
    dec_count       = 2'd0;
    dec_acc         = 8'd0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_plain_bytes();
    test_letter_escape();
    test_hex_escapes();
    test_octal_escapes();
    test_string_ends();
    test_receiver_hold();
    test_sender_pause();
    test_random_strings(200);

    // stretch without any idling on either side
    wait_drained();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    test_random_strings(290);
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    test_random_strings(380);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d raw words, checked %0d decoded bytes, %0d mismatches",
             words_sent, bytes_checked, mismatches);
    $display("letter, quote, hex and octal escapes, cut strings, output hold, input pause");
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("[string_escape_decoder] OK");
    end else begin
      $display("[string_escape_decoder] ERROR");
    end
    $finish;
  end

endmodule
